### design/rspe_pkg.sv
// ----------------------------------------------------------------------------
// Reed-Solomon parity encoder package
// Shared types, register codes and the GF(256) multiply used by the encoder
// top level and its cells.
// ----------------------------------------------------------------------------
package rspe_pkg;

  // Field widths of the stream and configuration payloads.
  localparam int BYTE_W       = 8;
  localparam int ECC_LEN_W    = 6;
  localparam int FIELD_POLY_W = 9;
  localparam int CFG_INDEX_W  = 1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_ECC_LEN    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIELD_POLY = 1'b1;

  // Register values after reset.
  localparam logic [ECC_LEN_W-1:0]    ECC_LEN_RESET    = 6'd10;
  localparam logic [FIELD_POLY_W-1:0] FIELD_POLY_RESET = 9'd285;

  // Encoder sequencing.
  typedef enum logic [1:0] {
    ST_BUILD,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // Per-cycle commands broadcast along the row of cells.
  typedef struct packed {
    logic gen_init;  // load the generator with the constant polynomial 1
    logic gen_step;  // multiply the generator by (x + root)
    logic enc_step;  // divide one data byte into the remainder
    logic shift;     // move the remainder one cell up for read-out
    logic clear;     // zero the remainder
  } cell_ctrl_t;

  // Shift-and-add multiply in GF(256); red is the low byte of the field
  // polynomial.
  function automatic logic [BYTE_W-1:0] gf_mul(
    input logic [BYTE_W-1:0] a,
    input logic [BYTE_W-1:0] b,
    input logic [BYTE_W-1:0] red
  );
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] aa;
    acc = '0;
    aa  = a;
    for (int k = 0; k < BYTE_W; k++) begin
      if (b[k]) begin
        acc = acc ^ aa;
      end
      if (aa[BYTE_W-1]) begin
        aa = {aa[BYTE_W-2:0], 1'b0} ^ red;
      end else begin
        aa = {aa[BYTE_W-2:0], 1'b0};
      end
    end
    return acc;
  endfunction

endpackage

### design/reed_solomon_parity_encoder_top.sv
// ----------------------------------------------------------------------------
// Reed-Solomon parity encoder
// Systematic GF(256) encoder: echoes data bytes, then appends the parity.
// ----------------------------------------------------------------------------
// One data byte is accepted per clock in the run state while the output is
// free, and appears on the output in the next cycle; a row of MAX_PARITY
// cells, each doing one GF multiply per byte, updates the remainder. The
// request that carries the last byte of a codeword is followed by n parity
// bytes (n is ecc_len clamped to 1 .. MAX_PARITY), read out of the cell row
// one per cycle while the output is free, and no new byte is taken until the
// last of them has been loaded into the output register. After reset, and
// before the first byte of a codeword that follows a register write, the
// generator polynomial is built in the same cells (an init step, then one
// step per parity byte) while s_axis_tready is low. A write to field_poly
// inside an open codeword changes the multiply of the bytes that follow but
// not the generator; a write to ecc_len takes effect at the next codeword.
// ----------------------------------------------------------------------------
module reed_solomon_parity_encoder_top #(
  parameter int MAX_PARITY = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rspe_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rspe_pkg::FIELD_POLY_W-1:0] cfg_data,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rspe_pkg::BYTE_W-1:0]       s_axis_tdata,   // [7:0] data_byte
  input  logic                              s_axis_tlast,   // last_byte
  // Output stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rspe_pkg::BYTE_W-1:0]       m_axis_tdata,   // [7:0] out_byte
  output logic                              m_axis_tuser,   // [0] is_parity
  output logic                              m_axis_tlast    // end_of_codeword
);

  localparam int CW = $clog2(MAX_PARITY + 1);
  localparam int IW = $clog2(MAX_PARITY);
  localparam int NW = 7;
  localparam logic [NW-1:0] MAX_N = NW'(MAX_PARITY);

  // Configuration registers.
  logic [rspe_pkg::ECC_LEN_W-1:0]    ecc_len;
  logic [rspe_pkg::FIELD_POLY_W-1:0] field_poly;
  logic                              cfg_wr;

  // Sequencing state.
  rspe_pkg::state_t state, state_next;
  logic             dirty, dirty_next;
  logic             in_word, in_word_next;
  logic [CW-1:0]    cw_len, cw_len_next;
  logic [CW-1:0]    build_cnt, build_cnt_next;
  logic [CW-1:0]    drain_cnt, drain_cnt_next;
  logic [rspe_pkg::BYTE_W-1:0] root, root_next;

  // Output register.
  logic                        out_free;
  logic                        out_load;
  logic [rspe_pkg::BYTE_W-1:0] out_byte_next;
  logic                        out_par_next;
  logic                        out_eoc_next;

  // Cell row.
  rspe_pkg::cell_ctrl_t        ctrl;
  logic [rspe_pkg::BYTE_W-1:0] red;
  logic [rspe_pkg::BYTE_W-1:0] fb;
  logic [rspe_pkg::BYTE_W-1:0] top_par;
  logic [IW-1:0]               top_sel;
  logic [rspe_pkg::BYTE_W-1:0] gen_vec [MAX_PARITY];
  logic [rspe_pkg::BYTE_W-1:0] par_vec [MAX_PARITY];

  logic          in_acc;
  logic [NW-1:0] ecc_ext;
  logic [NW-1:0] n_clamp;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;
  assign red       = field_poly[rspe_pkg::BYTE_W-1:0];

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ecc_len    <= rspe_pkg::ECC_LEN_RESET;
      field_poly <= rspe_pkg::FIELD_POLY_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        rspe_pkg::CFG_ECC_LEN: begin
          ecc_len <= cfg_data[rspe_pkg::ECC_LEN_W-1:0];
        end
        rspe_pkg::CFG_FIELD_POLY: begin
          field_poly <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Parity count clamped to the range the cell row supports.
  assign ecc_ext = NW'(ecc_len);
  always_comb begin
    priority if (ecc_ext == '0) begin
      n_clamp = NW'(1);
    end else if (ecc_ext > MAX_N) begin
      n_clamp = MAX_N;
    end else begin
      n_clamp = ecc_ext;
    end
  end

  // Highest-degree remainder byte feeds the division and the read-out.
  assign top_sel = IW'(cw_len - CW'(1));
  assign top_par = par_vec[top_sel];
  assign fb      = s_axis_tdata ^ top_par;

  // Handshakes: a stored result that is being taken frees the slot.
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == rspe_pkg::ST_RUN) && out_free &&
                         (in_word || (!dirty && !cfg_valid));
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Next state and cell commands.
  always_comb begin
    state_next     = state;
    dirty_next     = dirty || cfg_wr;
    in_word_next   = in_word;
    cw_len_next    = cw_len;
    build_cnt_next = build_cnt;
    drain_cnt_next = drain_cnt;
    root_next      = root;
    ctrl           = '0;
    out_load       = 1'b0;
    out_byte_next  = s_axis_tdata;
    out_par_next   = 1'b0;
    out_eoc_next   = 1'b0;
    unique case (state)
      rspe_pkg::ST_BUILD: begin
        priority if (dirty) begin
          ctrl.gen_init  = 1'b1;
          cw_len_next    = CW'(n_clamp);
          root_next      = rspe_pkg::BYTE_W'(1);
          build_cnt_next = '0;
          dirty_next     = cfg_wr;
        end else if (build_cnt != cw_len) begin
          ctrl.gen_step  = 1'b1;
          root_next      = rspe_pkg::gf_mul(root, rspe_pkg::BYTE_W'(2), red);
          build_cnt_next = build_cnt + CW'(1);
        end else begin
          state_next = rspe_pkg::ST_RUN;
        end
      end
      rspe_pkg::ST_RUN: begin
        if (in_acc) begin
          ctrl.enc_step = 1'b1;
          out_load      = 1'b1;
          if (s_axis_tlast) begin
            in_word_next   = 1'b0;
            drain_cnt_next = cw_len;
            state_next     = rspe_pkg::ST_DRAIN;
          end else begin
            in_word_next = 1'b1;
          end
        end else if (dirty && !in_word) begin
          state_next = rspe_pkg::ST_BUILD;
        end
      end
      rspe_pkg::ST_DRAIN: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_byte_next  = top_par;
          out_par_next   = 1'b1;
          drain_cnt_next = drain_cnt - CW'(1);
          if (drain_cnt == CW'(1)) begin
            out_eoc_next = 1'b1;
            ctrl.clear   = 1'b1;
            state_next   = rspe_pkg::ST_RUN;
          end else begin
            ctrl.shift = 1'b1;
          end
        end
      end
      default: begin
        state_next = rspe_pkg::ST_BUILD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rspe_pkg::ST_BUILD;
      dirty         <= 1'b1;
      in_word       <= 1'b0;
      cw_len        <= '0;
      build_cnt     <= '0;
      drain_cnt     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state     <= state_next;
      dirty     <= dirty_next;
      in_word   <= in_word_next;
      cw_len    <= cw_len_next;
      build_cnt <= build_cnt_next;
      drain_cnt <= drain_cnt_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    root <= root_next;
    if (out_load) begin
      m_axis_tdata <= out_byte_next;
      m_axis_tuser <= out_par_next;
      m_axis_tlast <= out_eoc_next;
    end
  end

  // Row of cells, index equal to the degree of the term each one holds.
  for (genvar k = 0; k < MAX_PARITY; k++) begin : g_cell
    logic [rspe_pkg::BYTE_W-1:0] gen_in;
    logic [rspe_pkg::BYTE_W-1:0] par_in;
    if (k == 0) begin : g_first
      assign gen_in = '0;
      assign par_in = '0;
    end else begin : g_rest
      assign gen_in = gen_vec[k-1];
      assign par_in = par_vec[k-1];
    end
    rspe_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .seed    (k == 0),
      .red     (red),
      .root    (root),
      .fb      (fb),
      .gen_in  (gen_in),
      .par_in  (par_in),
      .gen_out (gen_vec[k]),
      .par_out (par_vec[k])
    );
  end

endmodule

### design/rspe_cell.sv
// ----------------------------------------------------------------------------
// Reed-Solomon encoder cell
// Holds one generator coefficient and one remainder byte of the same degree.
// Takes the next lower cell's values to build the generator and to divide.
// ----------------------------------------------------------------------------
module rspe_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  rspe_pkg::cell_ctrl_t        ctrl,
  input  logic                        seed,      // generator value at init
  input  logic [rspe_pkg::BYTE_W-1:0] red,       // field polynomial low byte
  input  logic [rspe_pkg::BYTE_W-1:0] root,      // current generator root
  input  logic [rspe_pkg::BYTE_W-1:0] fb,        // division feedback byte
  input  logic [rspe_pkg::BYTE_W-1:0] gen_in,    // coefficient one degree down
  input  logic [rspe_pkg::BYTE_W-1:0] par_in,    // remainder one degree down
  output logic [rspe_pkg::BYTE_W-1:0] gen_out,
  output logic [rspe_pkg::BYTE_W-1:0] par_out
);

  logic [rspe_pkg::BYTE_W-1:0] gen;
  logic [rspe_pkg::BYTE_W-1:0] par;
  logic [rspe_pkg::BYTE_W-1:0] gen_next;
  logic [rspe_pkg::BYTE_W-1:0] par_next;

  // Generator build: g(k) becomes g(k-1) + g(k) * root.
  always_comb begin
    priority if (ctrl.gen_init) begin
      gen_next = {{(rspe_pkg::BYTE_W-1){1'b0}}, seed};
    end else if (ctrl.gen_step) begin
      gen_next = gen_in ^ rspe_pkg::gf_mul(gen, root, red);
    end else begin
      gen_next = gen;
    end
  end

  // Remainder update: division step, read-out shift or clear.
  always_comb begin
    priority if (ctrl.clear) begin
      par_next = '0;
    end else if (ctrl.shift) begin
      par_next = par_in;
    end else if (ctrl.enc_step) begin
      par_next = par_in ^ rspe_pkg::gf_mul(fb, gen, red);
    end else begin
      par_next = par;
    end
  end

  // The generator is always rebuilt before use, so it needs no reset.
  always_ff @(posedge clk) begin
    gen <= gen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      par <= '0;
    end else begin
      par <= par_next;
    end
  end

  assign gen_out = gen;
  assign par_out = par;

endmodule

### tb/sv/tb_reed_solomon_parity_encoder_top.sv
// ----------------------------------------------------------------------------
// Reed-Solomon parity encoder testbench
// Streams codewords through the encoder and checks every echoed data byte and
// every parity byte against a GF(256) long-division model kept in the bench.
// ----------------------------------------------------------------------------
// A short directed sequence covers the extremes of the data byte, single-byte
// codewords, the smallest and largest parity counts, out-of-range parity
// counts, odd field polynomials, and register writes inside an open codeword.
// Random codewords follow, with random register settings between them, random
// idling on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_reed_solomon_parity_encoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                          PARITY_MAX   = 32;
  localparam logic [rspe_pkg::BYTE_W-1:0] ALPHA        = 8'h02;
  localparam int                          IDLE_PCT     = 31;
  localparam int                          RANDOM_BYTES = 260;
  localparam int                          HOLD_CYCLES  = 200;

  // One byte leaving the encoder.
  typedef struct packed {
    logic [rspe_pkg::BYTE_W-1:0] value;
    logic                        parity;
    logic                        word_end;
  } cw_byte_t;

  // Running model of the encoder: remainder, generator and the bytes still due.
  class codeword_tracker;
    logic [rspe_pkg::ECC_LEN_W-1:0]    ecc_len;
    logic [rspe_pkg::FIELD_POLY_W-1:0] field_poly;
    logic [rspe_pkg::BYTE_W-1:0]       remainder [PARITY_MAX];
    logic [rspe_pkg::BYTE_W-1:0]       gen [PARITY_MAX+1];
    int unsigned                       word_parity;
    bit                                open_word;
    cw_byte_t                          due_bytes [$];
    int                                failures;
    int                                checked;

    function new();
      ecc_len     = rspe_pkg::ECC_LEN_RESET;
      field_poly  = rspe_pkg::FIELD_POLY_RESET;
      foreach (remainder[i]) remainder[i] = '0;
      foreach (gen[i]) gen[i] = '0;
      word_parity = 0;
      open_word   = 1'b0;
      failures    = 0;
      checked     = 0;
    endfunction

    // Horner-style product, reducing by the low byte of the field polynomial.
    function logic [rspe_pkg::BYTE_W-1:0] gf_product(logic [rspe_pkg::BYTE_W-1:0] a,
                                                     logic [rspe_pkg::BYTE_W-1:0] b);
      logic [rspe_pkg::BYTE_W-1:0] acc;
      acc = '0;
      for (int k = rspe_pkg::BYTE_W - 1; k >= 0; k--) begin
        acc = {acc[rspe_pkg::BYTE_W-2:0], 1'b0} ^
              (acc[rspe_pkg::BYTE_W-1] ? field_poly[rspe_pkg::BYTE_W-1:0] : '0);
        if (b[k]) begin
          acc = acc ^ a;
        end
      end
      return acc;
    endfunction

    // Generator polynomial: product of (x + alpha^i), parity count clamped.
    function void make_generator();
      int unsigned n;
      logic [rspe_pkg::BYTE_W-1:0] root;
      n = 32'(ecc_len);
      if (n < 1) n = 1;
      if (n > PARITY_MAX) n = PARITY_MAX;
      word_parity = n;
      foreach (gen[i]) gen[i] = '0;
      gen[0] = 8'h01;
      root   = 8'h01;
      for (int i = 0; i < n; i++) begin
        for (int k = i + 1; k > 0; k--) begin
          gen[k] = gen[k-1] ^ gf_product(gen[k], root);
        end
        gen[0] = gf_product(gen[0], root);
        root   = gf_product(root, ALPHA);
      end
    endfunction

    function void write_reg(logic [rspe_pkg::CFG_INDEX_W-1:0] idx,
                            logic [rspe_pkg::FIELD_POLY_W-1:0] value);
      if (idx == rspe_pkg::CFG_ECC_LEN) begin
        ecc_len = value[rspe_pkg::ECC_LEN_W-1:0];
      end else if (idx == rspe_pkg::CFG_FIELD_POLY) begin
        field_poly = value;
      end
    endfunction

    // An accepted data byte: echo it, divide it in, and on the last byte
    // queue the remainder as parity.
    function void take_byte(logic [rspe_pkg::BYTE_W-1:0] data, logic last);
      logic [rspe_pkg::BYTE_W-1:0] fb;
      int unsigned n;
      if (!open_word) begin
        make_generator();
        foreach (remainder[i]) remainder[i] = '0;
        open_word = 1'b1;
      end
      n  = word_parity;
      fb = data ^ remainder[0];
      for (int i = 0; i + 1 < n; i++) begin
        remainder[i] = remainder[i+1] ^ gf_product(fb, gen[n-1-i]);
      end
      remainder[n-1] = gf_product(fb, gen[0]);
      due_bytes.push_back('{value: data, parity: 1'b0, word_end: 1'b0});
      if (last) begin
        for (int i = 0; i < n; i++) begin
          due_bytes.push_back('{value: remainder[i], parity: 1'b1, word_end: (i + 1 == n)});
        end
        foreach (remainder[i]) remainder[i] = '0;
        open_word = 1'b0;
      end
    endfunction

    function void check_byte(logic [rspe_pkg::BYTE_W-1:0] value, logic parity,
                             logic word_end);
      cw_byte_t want;
      checked++;
      if (due_bytes.size() == 0) begin
        $error("unexpected output byte %02h (is_parity %0b, end_of_codeword %0b)",
               value, parity, word_end);
        failures++;
        return;
      end
      want = due_bytes.pop_front();
      if (value !== want.value) begin
        $error("out_byte: expected %02h, got %02h", want.value, value);
        failures++;
      end
      if (parity !== want.parity) begin
        $error("is_parity: expected %0b, got %0b", want.parity, parity);
        failures++;
      end
      if (word_end !== want.word_end) begin
        $error("end_of_codeword: expected %0b, got %0b", want.word_end, word_end);
        failures++;
      end
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [rspe_pkg::CFG_INDEX_W-1:0]  cfg_index = rspe_pkg::CFG_ECC_LEN;
  logic [rspe_pkg::FIELD_POLY_W-1:0] cfg_data = '0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [rspe_pkg::BYTE_W-1:0]       s_axis_tdata = '0;   // [7:0] data_byte
  logic                              s_axis_tlast = 1'b0; // last_byte
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [rspe_pkg::BYTE_W-1:0]       m_axis_tdata;        // [7:0] out_byte
  logic                              m_axis_tuser;        // [0] is_parity
  logic                              m_axis_tlast;        // end_of_codeword

  codeword_tracker tracker = new();

  // steady and hold_request are shared by the sender and receiver; the counters feed the summary.
  bit steady = 1'b0;
  bit hold_request = 1'b0;
  int data_count = 0;
  int word_count = 0;
  int reg_writes = 0;

  reed_solomon_parity_encoder_top #(.MAX_PARITY(PARITY_MAX)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Offer one data byte, with a random gap first, and wait for its request
  // to be accepted.
  task automatic send_byte(input logic [rspe_pkg::BYTE_W-1:0] data, input logic last);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tracker.take_byte(data, last);
    data_count++;
    if (last) word_count++;
  endtask

  // Stop offering and wait until every expected byte has come out.
  task automatic wait_drained(input int settle);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.due_bytes.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rspe_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [rspe_pkg::FIELD_POLY_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, value);
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [rspe_pkg::FIELD_POLY_W-1:0] ecc,
                          input logic [rspe_pkg::FIELD_POLY_W-1:0] poly);
    write_reg(rspe_pkg::CFG_ECC_LEN, ecc);
    write_reg(rspe_pkg::CFG_FIELD_POLY, poly);
  endtask

  // Receiver: check each accepted byte, then choose the next ready value.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
        tracker.check_byte(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Main sequence.
  initial begin : stimulus
    int len;
    int sent;
    bit held;
    sent = 0;
    held = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings, extremes of the data byte.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);

    // Single parity byte, single data byte.
    wait_drained(4);
    write_reg(rspe_pkg::CFG_ECC_LEN, 9'd1);
    send_byte(8'hFF, 1'b1);

    // Largest parity count with every field polynomial bit set.
    wait_drained(4);
    set_regs(9'd32, 9'd511);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hFF, 1'b1);

    // Parity count below range, field polynomial with no reduction bits.
    wait_drained(4);
    set_regs(9'd0, 9'd256);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b1);

    // Parity count above range, field polynomial with bit 8 clear.
    wait_drained(4);
    set_regs(9'd63, 9'd0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b1);

    // Writes inside an open codeword: the parity count waits for the next
    // codeword, the field polynomial applies to the bytes that follow.
    wait_drained(4);
    set_regs(9'd5, 9'd285);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    wait_drained(4);
    set_regs(9'd7, 9'd301);
    send_byte(8'h78, 1'b0);
    send_byte(8'h9A, 1'b0);
    send_byte(8'hBC, 1'b1);
    send_byte(8'hDE, 1'b0);
    send_byte(8'hF0, 1'b1);

    // Random codewords, with random settings between some of them.
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(3) == 0) begin
        wait_drained(4);
        if ($urandom_range(1) == 0) begin
          write_reg(rspe_pkg::CFG_ECC_LEN,
                    rspe_pkg::FIELD_POLY_W'(($urandom_range(7) == 0) ? $urandom_range(63)
                                                                   : $urandom_range(1, 32)));
        end
        if ($urandom_range(1) == 0) begin
          case ($urandom_range(3))
            0: write_reg(rspe_pkg::CFG_FIELD_POLY,
                         rspe_pkg::FIELD_POLY_W'($urandom_range(511)));
            1: write_reg(rspe_pkg::CFG_FIELD_POLY,
                         rspe_pkg::FIELD_POLY_W'($urandom_range(256, 511)));
            default: write_reg(rspe_pkg::CFG_FIELD_POLY, 9'd285);
          endcase
        end
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        steady = (sent >= 100 && sent < 170);
        if (!held && sent >= 200) begin
          hold_request = 1'b1;
          held = 1'b1;
        end
        send_byte(rspe_pkg::BYTE_W'($urandom_range(255)), i == len - 1);
        sent++;
      end
    end

    wait_drained(40);
    if (tracker.due_bytes.size() != 0) begin
      $error("%0d expected output bytes never arrived", tracker.due_bytes.size());
      tracker.failures++;
    end
    $display("Encoded %0d codewords from %0d data bytes, %0d output bytes checked,",
             word_count, data_count, tracker.checked);
    $display("with %0d register writes, random idling and one long receiver hold-off.",
             reg_writes);
    if (tracker.failures == 0) begin
      $display("[reed_solomon_parity_encoder_top] OK");
    end else begin
      $display("[reed_solomon_parity_encoder_top] ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #2_000_000;
    $display("[reed_solomon_parity_encoder_top] ERROR");
    $finish;
  end

endmodule
